FILE: src/tws_pkg.sv
// Package for the three-wire serial master.
// Holds the transaction and result types, the register file type and its constants.
// No dependencies.
package tws_pkg;

   localparam int unsigned CsrIndexWidth = 1;

   localparam logic [CsrIndexWidth-1:0] CSR_BIT_WAIT  = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TURN_WAIT = 1'd1;

   localparam logic [7:0] BIT_WAIT_RESET  = 8'd5;
   localparam logic [7:0] TURN_WAIT_RESET = 8'd8;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   localparam logic [3:0] LAST_BIT      = 4'd15;
   localparam logic [3:0] FIRST_DATA_BIT = 4'd8;

   typedef struct packed {
      logic       func;
      logic       is_read;
      logic [7:0] command_byte;
      logic [7:0] write_data;
      logic       io_in;
   } item_type;

   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       data_out;
      logic       data_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
   } result_type;

   typedef struct packed {
      logic [7:0] bit_wait;
      logic [7:0] turnaround_wait;
   } cfg_type;

endpackage

FILE: src/tws_engine.sv
// Bit engine of the three-wire serial master: sequencer state and result register.
// Each stepped transaction advances the sequencer once and registers its result.
// Depends on tws_pkg.
module tws_engine
   import tws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SETUP,
      PH_HOLD,
      PH_TURN
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  wait_count_ff, wait_count_in;
   logic [15:0] out_shift_ff, out_shift_in;
   logic [7:0]  in_shift_ff, in_shift_in;
   logic        read_mode_ff, read_mode_in;
   logic        enable_ff, enable_in;
   logic        drive_ff, drive_in;
   result_type  result_ff, result_in;

   always_comb begin
      logic [7:0] cmd;
      logic       clk_pulse;
      logic       done;
      logic [7:0] rdata;

      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      wait_count_in = wait_count_ff;
      out_shift_in  = out_shift_ff;
      in_shift_in   = in_shift_ff;
      read_mode_in  = read_mode_ff;
      enable_in     = enable_ff;
      drive_in      = drive_ff;
      clk_pulse     = 1'b0;
      done          = 1'b0;
      rdata         = 8'd0;
      cmd           = item.is_read ? (item.command_byte | 8'h01)
                                   : (item.command_byte & 8'hFE);

      if (item.func == FUNC_START) begin
         if (phase_ff == PH_IDLE) begin
            read_mode_in  = item.is_read;
            out_shift_in  = {item.write_data, cmd};
            in_shift_in   = 8'd0;
            bit_count_in  = 4'd0;
            enable_in     = 1'b1;
            drive_in      = 1'b1;
            wait_count_in = cfg.bit_wait;
            phase_in      = PH_SETUP;
         end
      end else if (phase_ff != PH_IDLE) begin
         if (wait_count_ff != 8'd0) begin
            wait_count_in = wait_count_ff - 8'd1;
         end else if (phase_ff == PH_SETUP) begin
            clk_pulse     = 1'b1;
            wait_count_in = cfg.bit_wait;
            phase_in      = PH_HOLD;
         end else if (phase_ff == PH_TURN) begin
            in_shift_in   = {item.io_in, in_shift_ff[7:1]};
            wait_count_in = cfg.bit_wait;
            phase_in      = PH_SETUP;
         end else if (bit_count_ff == LAST_BIT) begin
            done         = 1'b1;
            rdata        = read_mode_ff ? in_shift_ff : 8'd0;
            enable_in    = 1'b0;
            drive_in     = 1'b0;
            bit_count_in = 4'd0;
            phase_in     = PH_IDLE;
         end else begin
            bit_count_in = bit_count_ff + 4'd1;
            out_shift_in = {1'b0, out_shift_ff[15:1]};
            if (read_mode_ff && bit_count_in == FIRST_DATA_BIT) begin
               drive_in      = 1'b0;
               wait_count_in = cfg.turnaround_wait;
               phase_in      = PH_TURN;
            end else begin
               if (read_mode_ff && bit_count_in > FIRST_DATA_BIT) begin
                  in_shift_in = {item.io_in, in_shift_ff[7:1]};
               end
               wait_count_in = cfg.bit_wait;
               phase_in      = PH_SETUP;
            end
         end
      end

      result_in.chip_enable  = enable_in;
      result_in.serial_clock = clk_pulse;
      result_in.data_out     = drive_in & out_shift_in[0];
      result_in.data_drive   = drive_in;
      result_in.busy_res     = (phase_in != PH_IDLE);
      result_in.done_res     = done;
      result_in.read_data    = rdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 4'd0;
         wait_count_ff <= 8'd0;
         out_shift_ff  <= 16'd0;
         in_shift_ff   <= 8'd0;
         read_mode_ff  <= 1'b0;
         enable_ff     <= 1'b0;
         drive_ff      <= 1'b0;
         result_ff     <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         wait_count_ff <= wait_count_in;
         out_shift_ff  <= out_shift_in;
         in_shift_ff   <= in_shift_in;
         read_mode_ff  <= read_mode_in;
         enable_ff     <= enable_in;
         drive_ff      <= drive_in;
         result_ff     <= result_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: src/three_wire_serial_master_unit.sv
// Top level of the three-wire serial master: input register, result register and handshakes.
// Depends on tws_pkg and tws_engine.
//
// Usage: each request transaction is either one time tick (func low) or a transfer start
// (func high). Every request yields exactly one response transaction carrying the pin
// levels after that request: chip enable, serial clock, data level and drive, busy, done
// and the read byte on the transaction that ends a read.
// A request that is taken is registered in the input register, then stepped through the
// bit sequencer into the result register and presented on rsp_valid from then on.
// Throughput is one transaction per cycle while rsp_stall is low; the sequencer state is
// updated once per transaction, so with rsp_stall low a request can be taken at every edge.
// When rsp_stall is high the response holds; the input register then fills and req_stall
// rises until the response is taken.
// Synchronous reset empties both registers, returns the sequencer to idle with chip
// enable low and the line released, and loads bit_wait = 5 and turnaround_wait = 8.
// The user must write the csr port only while no transaction is in flight; the block does not enforce this.
module three_wire_serial_master_unit
   import tws_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic                     req_is_read,
   input  logic [7:0]               req_command_byte,
   input  logic [7:0]               req_write_data,
   input  logic                     req_io_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_chip_enable,
   output logic                     rsp_serial_clock,
   output logic                     rsp_data_out,
   output logic                     rsp_data_drive,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [7:0]               rsp_read_data,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [7:0]               csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   cfg_type    cfg_ff;
   logic       out_load;
   logic       req_take;
   result_type result;

   assign out_load    = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall   = in_valid_ff & ~out_load;
   assign req_take    = req_valid & ~req_stall;
   assign in_valid_in = req_take | (in_valid_ff & ~out_load);
   assign out_valid_in = out_load | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.func         <= req_func;
         in_item_ff.is_read      <= req_is_read;
         in_item_ff.command_byte <= req_command_byte;
         in_item_ff.write_data   <= req_write_data;
         in_item_ff.io_in        <= req_io_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_wait        <= BIT_WAIT_RESET;
         cfg_ff.turnaround_wait <= TURN_WAIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BIT_WAIT:  cfg_ff.bit_wait        <= csr_wdata;
            CSR_TURN_WAIT: cfg_ff.turnaround_wait <= csr_wdata;
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   tws_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (out_load),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_chip_enable  = result.chip_enable;
   assign rsp_serial_clock = result.serial_clock;
   assign rsp_data_out     = result.data_out;
   assign rsp_data_drive   = result.data_drive;
   assign rsp_busy_res     = result.busy_res;
   assign rsp_done_res     = result.done_res;
   assign rsp_read_data    = result.read_data;

`ifndef ASSERT_OFF
   a_done_ends_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_chip_enable && !rsp_data_drive)
      else $error("done response still shows a transfer in progress");

   a_released_line_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_drive |-> !rsp_data_out)
      else $error("data level driven while the line is released");

   a_clock_inside_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_serial_clock |-> rsp_chip_enable && rsp_busy_res)
      else $error("serial clock pulse outside a transfer");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled while the pipeline can advance");
`endif

endmodule
